### src/nkd_pkg.sv
// nkd_pkg: shared types, constants and helper functions of the nibble key descrambler.
// No dependencies; used by nkd_unscramble and nibble_key_descrambler.
`timescale 1ns / 1ps
`default_nettype none

package nkd_pkg;

	typedef logic [2:0]  ring_t;
	typedef logic [3:0]  nib_t;
	typedef logic [7:0]  byte_t;
	typedef logic [31:0] key_t;

	// ring position codes: shift 16, 12, 8, 4, 0
	localparam ring_t RING_S16 = 3'd0;
	localparam ring_t RING_S12 = 3'd1;
	localparam ring_t RING_S8  = 3'd2;
	localparam ring_t RING_S4  = 3'd3;
	localparam ring_t RING_S0  = 3'd4;

	localparam key_t KEY_RESET = 32'h0000_0000;

	// 16-entry shuffle table
	function automatic nib_t shuffle(input nib_t idx);
		nib_t res;
		case (idx)
			4'h0: res = 4'hb;
			4'h1: res = 4'hc;
			4'h2: res = 4'ha;
			4'h3: res = 4'h0;
			4'h4: res = 4'h8;
			4'h5: res = 4'hf;
			4'h6: res = 4'h2;
			4'h7: res = 4'h1;
			4'h8: res = 4'h6;
			4'h9: res = 4'h4;
			4'ha: res = 4'h9;
			4'hb: res = 4'h3;
			4'hc: res = 4'hd;
			4'hd: res = 4'h5;
			4'he: res = 4'h7;
			default: res = 4'he;
		endcase
		return res;
	endfunction

	// next ring position; unused codes behave as shift 16
	function automatic ring_t ring_next(input ring_t pos);
		ring_t res;
		case (pos)
			RING_S16: res = RING_S12;
			RING_S12: res = RING_S8;
			RING_S8:  res = RING_S4;
			RING_S4:  res = RING_S0;
			RING_S0:  res = RING_S16;
			default:  res = RING_S12;
		endcase
		return res;
	endfunction

	// key nibble at the shift of a ring position
	function automatic nib_t key_nibble(input key_t key, input ring_t pos);
		nib_t res;
		case (pos)
			RING_S12: res = key[15:12];
			RING_S8:  res = key[11:8];
			RING_S4:  res = key[7:4];
			RING_S0:  res = key[3:0];
			default:  res = key[19:16];
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

### src/nkd_unscramble.sv
// nkd_unscramble: combinational byte descrambling for one ring position pair.
// Depends on nkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nkd_unscramble (
	input  wire nkd_pkg::byte_t cipher,
	input  wire nkd_pkg::ring_t pos,
	input  wire nkd_pkg::key_t  key,
	output nkd_pkg::byte_t      plain
);

	nkd_pkg::nib_t  key_sum;
	nkd_pkg::nib_t  kn_hi;
	nkd_pkg::nib_t  kn_lo;
	nkd_pkg::ring_t pos_lo;

	// low nibbles of the four key bytes, summed mod 16, then passed through the shuffle table
	assign key_sum = nkd_pkg::shuffle(key[3:0] + key[11:8] + key[19:16] + key[27:24]);
	assign pos_lo  = nkd_pkg::ring_next(pos);
	assign kn_hi   = nkd_pkg::key_nibble(key, pos);
	assign kn_lo   = nkd_pkg::key_nibble(key, pos_lo);

	assign plain[7:4] = cipher[7:4] - key_sum - kn_hi - nkd_pkg::shuffle(kn_hi);
	assign plain[3:0] = cipher[3:0] - key_sum - kn_lo - nkd_pkg::shuffle(kn_lo);

endmodule

`default_nettype wire

### src/nibble_key_descrambler.sv
// nibble_key_descrambler: top level; input register, ring counter, result register.
// Depends on nkd_pkg and nkd_unscramble.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - s_* stream carries scrambled bytes: s_tdata = cipher_byte, s_tlast = block_end.
//  - m_* stream returns one descrambled byte per request: m_tdata = plain_byte.
//  - cfg_wen/cfg_wdata write the 32-bit unlock key; write only while idle.
// Path: each request passes the input register, then the result register.
// Throughput: one byte per cycle unless m_tready stalls the output; requests may
//   follow back to back.
// Ring: each byte moves the ring position two steps (upper nibble, lower nibble).
//   After a byte marked with s_tlast the position restarts at shift 16.
// Reset (arst_n low): key cleared to zero, ring back to shift 16, both stages empty.
// Stall: when m_tready is low the result is held; the input stage still takes a
//   request while it is empty, then s_tready drops until the result moves on.
module nibble_key_descrambler (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] cipher_byte
	input  wire        s_tlast,   // block_end
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] plain_byte
	input  wire        cfg_wen,
	input  wire [31:0] cfg_wdata  // unlock_key
);

	nkd_pkg::key_t  key_q;
	nkd_pkg::ring_t ring_q;

	logic           vld_s1;
	nkd_pkg::byte_t byte_s1;
	nkd_pkg::ring_t pos_s1;

	logic           vld_s2;
	nkd_pkg::byte_t plain_s2;

	nkd_pkg::byte_t plain_c;
	logic           out_free;
	logic           adv_s1;
	logic           in_acc;

	assign out_free = !vld_s2 || m_tready;
	assign adv_s1   = vld_s1 && out_free;
	assign s_tready = !vld_s1 || adv_s1;
	assign in_acc   = s_tvalid && s_tready;

	// key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= nkd_pkg::KEY_RESET;
		end else if (cfg_wen) begin
			key_q <= cfg_wdata;
		end
	end

	// ring counter: two steps per byte, restart after block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= nkd_pkg::RING_S16;
		end else if (in_acc) begin
			ring_q <= s_tlast ? nkd_pkg::RING_S16
			                  : nkd_pkg::ring_next(nkd_pkg::ring_next(ring_q));
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_tdata;
			pos_s1  <= ring_q;
		end
	end

	nkd_unscramble u_unscramble (
		.cipher (byte_s1),
		.pos    (pos_s1),
		.key    (key_q),
		.plain  (plain_c)
	);

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= vld_s1;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			plain_s2 <= plain_c;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = plain_s2;

endmodule

`default_nettype wire

### src/nkd_checker.sv
// nkd_checker: port-level assertions for nibble_key_descrambler, with bind.
// Depends on nibble_key_descrambler ports only.
`timescale 1ns / 1ps
`default_nettype none

module nkd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata
);

	// stalled result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// stalled result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// free output side means the input side is ready
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input not ready with free output");

	// every request taken must be followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after request");

	// a new result needs an earlier request taken
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without request");

endmodule

bind nibble_key_descrambler nkd_checker u_nkd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### test/nibble_key_descrambler_checker.sv
// nibble_key_descrambler_checker: watches the byte streams and the key port of the descrambler,
// predicts every plain byte and compares it in order. Depends on nkd_pkg.
`timescale 1ns / 1ps

module nibble_key_descrambler_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire   [7:0] s_tdata,
	input  wire         s_tlast,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire   [7:0] m_tdata,
	input  wire         cfg_wen,
	input  wire  [31:0] cfg_wdata,
	output logic [31:0] mismatch_count,
	output logic [31:0] bytes_outstanding
);

	// shuffle entries, entry 0 in the lowest nibble: b c a 0 8 f 2 1 6 4 9 3 d 5 7 e
	localparam logic [63:0] SHUFFLE_TAB = 64'he75d_3946_12f8_0acb;
	localparam int REPORT_LIMIT = 10;

	nkd_pkg::key_t  shadow_key;
	nkd_pkg::ring_t shadow_ring;
	nkd_pkg::byte_t plain_due[$];
	nkd_pkg::byte_t plain_exp;
	int             err_total;

	function automatic nkd_pkg::nib_t shuffle_of(input nkd_pkg::nib_t idx);
		return SHUFFLE_TAB[int'(idx) * 4 +: 4];
	endfunction

	function automatic nkd_pkg::ring_t step_ring(input nkd_pkg::ring_t pos);
		return (pos == nkd_pkg::RING_S0) ? nkd_pkg::RING_S16 : nkd_pkg::ring_t'(pos + 3'd1);
	endfunction

	// key nibble at shift 16 - 4 * position
	function automatic nkd_pkg::nib_t key_nib_at(input nkd_pkg::key_t k,
			input nkd_pkg::ring_t pos);
		return nkd_pkg::nib_t'(k >> (16 - 4 * int'(pos)));
	endfunction

	function automatic nkd_pkg::nib_t strip_nibble(input nkd_pkg::nib_t nib,
			input nkd_pkg::nib_t key_sum, input nkd_pkg::nib_t kn);
		return nib - key_sum - kn - shuffle_of(kn);
	endfunction

	function automatic nkd_pkg::byte_t descramble(input nkd_pkg::key_t k,
			input nkd_pkg::ring_t pos, input nkd_pkg::byte_t cipher);
		nkd_pkg::nib_t sum_idx;
		nkd_pkg::nib_t key_sum;
		nkd_pkg::nib_t hi;
		nkd_pkg::nib_t lo;
		sum_idx = k[3:0] + k[11:8] + k[19:16] + k[27:24];
		key_sum = shuffle_of(sum_idx);
		hi = strip_nibble(cipher[7:4], key_sum, key_nib_at(k, pos));
		lo = strip_nibble(cipher[3:0], key_sum, key_nib_at(k, step_ring(pos)));
		return {hi, lo};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_key = nkd_pkg::KEY_RESET;
			shadow_ring = nkd_pkg::RING_S16;
			plain_due.delete();
			err_total = 0;
			mismatch_count <= '0;
			bytes_outstanding <= '0;
		end else begin
			// results first: a result can never belong to a request taken at this edge
			if (m_tvalid && m_tready) begin
				if (plain_due.size() == 0) begin
					if (err_total < REPORT_LIMIT)
						$display("%0t: unexpected plain byte %h, none pending",
							$realtime, m_tdata);
					err_total++;
				end else begin
					plain_exp = plain_due.pop_front();
					if (m_tdata !== plain_exp) begin
						if (err_total < REPORT_LIMIT)
							$display("%0t: plain_byte mismatch: expected %h, got %h",
								$realtime, plain_exp, m_tdata);
						err_total++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				plain_due.push_back(descramble(shadow_key, shadow_ring, s_tdata));
				shadow_ring = s_tlast ? nkd_pkg::RING_S16 : step_ring(step_ring(shadow_ring));
			end
			// new key applies from the next byte on
			if (cfg_wen)
				shadow_key = cfg_wdata;
			mismatch_count <= err_total;
			bytes_outstanding <= plain_due.size();
		end
	end

endmodule

### test/nibble_key_descrambler_test.sv
// nibble_key_descrambler_test: top of the descrambler bench; drives bytes, key writes and
// output stalls. Depends on nkd_pkg, nibble_key_descrambler and nibble_key_descrambler_checker.
`timescale 1ns / 1ps

module nibble_key_descrambler_test;

	localparam int BYTE_TARGET  = 1400;
	localparam int DRAIN_CYCLES = 8;       // idle margin after the last byte leaves the block
	localparam int CYCLE_LIMIT  = 400000;  // hard stop for a hung block

	// receiver behavior, picked anew for each random stretch
	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_tvalid = 1'b0;
	wire            s_tready;
	nkd_pkg::byte_t s_tdata = '0;
	logic           s_tlast = 1'b0;
	wire            m_tvalid;
	logic           m_tready = 1'b0;
	wire      [7:0] m_tdata;
	logic           cfg_wen = 1'b0;
	nkd_pkg::key_t  cfg_wdata = '0;

	wire     [31:0] mismatch_count;
	wire     [31:0] bytes_outstanding;

	// sender burst control
	int             burst_left = 0;
	bit             gaps_on = 1'b1;

	// receiver stall control
	rx_mode_t       rx_mode = RX_ALWAYS;
	int             rx_left = 0;

	int             cycle_count = 0;

	nibble_key_descrambler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	nibble_key_descrambler_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.cfg_wen           (cfg_wen),
		.cfg_wdata         (cfg_wdata),
		.mismatch_count    (mismatch_count),
		.bytes_outstanding (bytes_outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("nibble_key_descrambler_test failed");
			$finish;
		end
	end

	// Receiver: picks a stall mode for a random stretch of cycles. RX_ALWAYS gives
	// stretches with no back-pressure at all; the others stall at different rates.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 150);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: m_tready <= (rx_left % 3) != 0;
			default:     m_tready <= 1'b1;
		endcase
	end

	// Offer one byte and hold it until the request is taken. Bursts of random
	// length; between bursts the valid line drops for a random gap, unless gaps
	// are switched off for this phase. valid that stays high is never re-driven
	// in the same step it is lowered.
	task automatic send_byte(input nkd_pkg::byte_t data, input logic end_of_block);
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= end_of_block;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait for every predicted byte to come out, then let the
	// pipeline settle before anything touches the key.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (bytes_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one-cycle key write; only called with the block idle
	task automatic load_key(input nkd_pkg::key_t k);
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int            sent;
		int            phase_len;
		int            end_odds;
		int            bit_pos;
		nkd_pkg::key_t next_key;

		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: key still at its reset value of zero. Five bytes walk the ring
		// through all five shifts twice; then block ends after one and two bytes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hfe, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		quiesce();

		// all-ones key; the block is left open so the next key lands mid-block
		load_key(32'hffff_ffff);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h0f, 1'b0);
		send_byte(8'hf0, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h3c, 1'b1);
		send_byte(8'hc3, 1'b0);
		quiesce();

		// key change mid-block: ring position must carry on where it was
		load_key(32'h8000_0001);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'hed, 1'b0);
		quiesce();

		// explicit write of the zero key
		load_key(32'h0000_0000);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		quiesce();

		// Random phases: random bytes, block-end density and idling chosen per
		// phase; each phase ends with the stream drained and a new key.
		while (sent < BYTE_TARGET) begin
			phase_len = $urandom_range(40, 200);
			if (phase_len > BYTE_TARGET - sent)
				phase_len = BYTE_TARGET - sent;
			case ($urandom_range(0, 3))
				0:       end_odds = 2;
				1:       end_odds = 5;
				2:       end_odds = 50;
				default: end_odds = 0;   // one long block
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (phase_len) begin
				send_byte(nkd_pkg::byte_t'($urandom_range(0, 255)),
					end_odds != 0 && $urandom_range(1, end_odds) == 1);
				sent++;
			end
			quiesce();
			bit_pos = $urandom_range(0, 31);
			case ($urandom_range(0, 7))
				0:       next_key = 32'h0000_0000;
				1:       next_key = 32'hffff_ffff;
				2:       next_key = nkd_pkg::key_t'(1) << bit_pos;
				3:       next_key = ~(nkd_pkg::key_t'(1) << bit_pos);
				default: next_key = $urandom;
			endcase
			load_key(next_key);
		end

		gaps_on = 1'b1;
		quiesce();
		if (mismatch_count == 0 && bytes_outstanding == 0) begin
			$display("nibble_key_descrambler_test passed");
		end else begin
			$display("nibble_key_descrambler_test failed");
		end
		$finish;
	end

endmodule
